// ===== rtl/doaq_pkg.sv =====
// Package with the sizes, command codes and beat types of the deadline-ordered alarm queue.
`default_nettype none
package doaq_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LEN_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_UPDATE   = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  event_slot;
    logic [31:0] deadline;
    logic        event_kind;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  fired_slot;
    logic        fired_kind;
    logic [31:0] fired_payload;
    logic [31:0] fire_time;
    logic        last_of_run;
  } res_t;

  // One position of the sorted list: the slot and its deadline.
  typedef struct packed {
    logic [IDX_W-1:0]     slot;
    logic [TIME_BITS-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] payload;
  } kp_t;

endpackage
`default_nettype wire

// ===== rtl/deadline_ordered_alarm_queue_top.sv =====
// Top level of the deadline-ordered alarm queue: sorted list in a circular memory.
// Register or update: when queued, the list is read entry by entry to unlink the slot, then
// entries are moved one by one to insert it, as the list memory has a single read port.
// Tick: a list read, a slot data read and a capture per fired slot, until the head is not
// due or the list is empty; each beat leaves a registered output in the cycle after it is
// known whether it is the last. The receiver cannot stall: each beat shows for one cycle.
// Reset clears the tick counter, queue length, head and queued flags; memories hold garbage.
`default_nettype none
module deadline_ordered_alarm_queue_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire doaq_pkg::cmd_t cmd_i,
  output logic                busy,
  output logic                fire_valid_o,
  output doaq_pkg::res_t      fire_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_REM_RD = 8'b0000_0010,
    ST_REM_EX = 8'b0000_0100,
    ST_INS_RD = 8'b0000_1000,
    ST_INS_EX = 8'b0001_0000,
    ST_T_RD   = 8'b0010_0000,
    ST_T_EX   = 8'b0100_0000,
    ST_T_KP   = 8'b1000_0000
  } state_e;

  localparam int IW = doaq_pkg::IDX_W;
  localparam int LW = doaq_pkg::LEN_W;
  localparam int TW = doaq_pkg::TIME_BITS;
  localparam int N  = doaq_pkg::SLOT_COUNT;

  state_e                  state_q, state_d;
  logic [TW-1:0]           time_q, time_d;
  logic [LW-1:0]           len_q, len_d;
  logic [IW-1:0]           head_q, head_d;
  logic [N-1:0]            queued_q, queued_d;
  logic [LW-1:0]           cnt_q, cnt_d;
  logic                    found_q, found_d;
  logic                    pend_v_q, pend_v_d;
  logic [IW-1:0]           slot_q, slot_d;
  logic [TW-1:0]           dl_q, dl_d;
  logic [IW-1:0]           pend_slot_q, pend_slot_d;
  doaq_pkg::kp_t           pend_kp_q, pend_kp_d;
  logic                    fire_v_d;
  doaq_pkg::res_t          fire_q, fire_d;
  logic                    fire_v_q;

  doaq_pkg::entry_t        list_mem [N];
  doaq_pkg::kp_t           kp_mem [N];
  doaq_pkg::entry_t        list_rd_q, list_wdata;
  doaq_pkg::kp_t           kp_rd_q;
  logic                    list_re, list_we, kp_re, kp_we;
  logic [IW-1:0]           list_raddr, list_waddr, kp_raddr, kp_waddr;
  logic                    accept;
  doaq_pkg::entry_t        new_entry;

  // Logical list position to memory address, relative to the head.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [LW-1:0] p);
    logic [LW:0] s;
    s = (LW+1)'(head) + (LW+1)'(p);
    if (s >= (LW+1)'(N)) begin
      s = s - (LW+1)'(N);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
    logic [IW-1:0] r;
    r = (32'(x) == N - 1) ? '0 : x + IW'(1);
    return r;
  endfunction

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign new_entry = '{slot: slot_q, deadline: dl_q};

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    len_d       = len_q;
    head_d      = head_q;
    queued_d    = queued_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    pend_v_d    = pend_v_q;
    slot_d      = slot_q;
    dl_d        = dl_q;
    pend_slot_d = pend_slot_q;
    pend_kp_d   = pend_kp_q;
    fire_v_d    = 1'b0;
    fire_d      = fire_q;
    list_re     = 1'b0;
    list_raddr  = '0;
    list_we     = 1'b0;
    list_waddr  = '0;
    list_wdata  = new_entry;
    kp_re       = 1'b0;
    kp_raddr    = '0;
    kp_we       = 1'b0;
    kp_waddr    = cmd_i.event_slot[IW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((cmd_i.command == doaq_pkg::CMD_REGISTER ||
               cmd_i.command == doaq_pkg::CMD_UPDATE) && 32'(cmd_i.event_slot) < N) begin
            slot_d = cmd_i.event_slot[IW-1:0];
            dl_d   = cmd_i.deadline[TW-1:0];
            kp_we  = (cmd_i.command == doaq_pkg::CMD_REGISTER);
            if (queued_q[cmd_i.event_slot[IW-1:0]]) begin
              cnt_d   = '0;
              found_d = 1'b0;
              state_d = ST_REM_RD;
            end else begin
              cnt_d   = len_q;
              state_d = ST_INS_RD;
            end
          end else if (cmd_i.command == doaq_pkg::CMD_TICK) begin
            time_d   = time_q + TW'(1);
            pend_v_d = 1'b0;
            state_d  = ST_T_RD;
          end
        end
      end
      ST_REM_RD: begin
        if (cnt_q == len_q) begin
          len_d            = len_q - LW'(1);
          queued_d[slot_q] = 1'b0;
          cnt_d            = len_q - LW'(1);
          state_d          = ST_INS_RD;
        end else begin
          list_re    = 1'b1;
          list_raddr = phys(head_q, cnt_q);
          state_d    = ST_REM_EX;
        end
      end
      ST_REM_EX: begin
        // Entries behind the unlinked one slide down by one position.
        if (found_q) begin
          list_we    = 1'b1;
          list_waddr = phys(head_q, cnt_q - LW'(1));
          list_wdata = list_rd_q;
        end
        if (list_rd_q.slot == slot_q) begin
          found_d = 1'b1;
        end
        cnt_d   = cnt_q + LW'(1);
        state_d = ST_REM_RD;
      end
      ST_INS_RD: begin
        if (cnt_q == '0) begin
          list_we          = 1'b1;
          list_waddr       = head_q;
          len_d            = len_q + LW'(1);
          queued_d[slot_q] = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          list_re    = 1'b1;
          list_raddr = phys(head_q, cnt_q - LW'(1));
          state_d    = ST_INS_EX;
        end
      end
      ST_INS_EX: begin
        list_we    = 1'b1;
        list_waddr = phys(head_q, cnt_q);
        // The new entry goes ahead of every entry with an equal or later deadline.
        if (list_rd_q.deadline >= dl_q) begin
          list_wdata = list_rd_q;
          cnt_d      = cnt_q - LW'(1);
          state_d    = ST_INS_RD;
        end else begin
          len_d            = len_q + LW'(1);
          queued_d[slot_q] = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_T_RD: begin
        if (len_q == '0) begin
          fire_v_d = pend_v_q;
          fire_d   = '{fired_slot: 4'(pend_slot_q), fired_kind: pend_kp_q.kind,
                       fired_payload: pend_kp_q.payload, fire_time: 32'(time_q),
                       last_of_run: 1'b1};
          state_d  = ST_IDLE;
        end else begin
          list_re    = 1'b1;
          list_raddr = head_q;
          state_d    = ST_T_EX;
        end
      end
      ST_T_EX: begin
        // The held beat goes out once it is known whether another slot follows.
        fire_v_d = pend_v_q;
        fire_d   = '{fired_slot: 4'(pend_slot_q), fired_kind: pend_kp_q.kind,
                     fired_payload: pend_kp_q.payload, fire_time: 32'(time_q),
                     last_of_run: 1'b1};
        if (list_rd_q.deadline > time_q) begin
          state_d = ST_IDLE;
        end else begin
          fire_d.last_of_run         = 1'b0;
          kp_re                      = 1'b1;
          kp_raddr                   = list_rd_q.slot;
          pend_slot_d                = list_rd_q.slot;
          head_d                     = inc_idx(head_q);
          len_d                      = len_q - LW'(1);
          queued_d[list_rd_q.slot]   = 1'b0;
          state_d                    = ST_T_KP;
        end
      end
      ST_T_KP: begin
        pend_v_d  = 1'b1;
        pend_kp_d = kp_rd_q;
        state_d   = ST_T_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_raddr];
    end
    if (kp_we) begin
      kp_mem[kp_waddr] <= '{kind: cmd_i.event_kind, payload: cmd_i.payload};
    end
    if (kp_re) begin
      kp_rd_q <= kp_mem[kp_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      time_q   <= '0;
      len_q    <= '0;
      head_q   <= '0;
      queued_q <= '0;
      pend_v_q <= 1'b0;
      fire_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      time_q   <= time_d;
      len_q    <= len_d;
      head_q   <= head_d;
      queued_q <= queued_d;
      pend_v_q <= pend_v_d;
      fire_v_q <= fire_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    found_q     <= found_d;
    slot_q      <= slot_d;
    dl_q        <= dl_d;
    pend_slot_q <= pend_slot_d;
    pend_kp_q   <= pend_kp_d;
    fire_q      <= fire_d;
  end

  assign fire_valid_o = fire_v_q;
  assign fire_o       = fire_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= N)
    else $error("queue length exceeds slot count");

  a_len_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(queued_q) == 32'(len_q))
    else $error("queued flags disagree with queue length");

  a_beat_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_v_d |-> (state_q == ST_T_RD || state_q == ST_T_EX))
    else $error("result beat outside a tick");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.command == doaq_pkg::CMD_TICK |=> state_q == ST_T_RD)
    else $error("tick not started");

endmodule
`default_nettype wire
